### rtl/sqd_pkg.sv
// Shared types and constants of the shortest-queue dispatch service.
package sqd_pkg;

   localparam int SQD_QUEUE_DEPTH = 16;
   localparam int NUM_QUEUES      = 3;

   localparam logic [2:0] EV_QUEUED = 3'd0;
   localparam logic [2:0] EV_START  = 3'd1;
   localparam logic [2:0] EV_DEPART = 3'd2;
   localparam logic [2:0] EV_TICK   = 3'd3;
   localparam logic [2:0] EV_REJECT = 3'd4;

   typedef struct packed {
      logic        action;
      logic [15:0] job_id;
      logic [3:0]  work_units;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [1:0]  queue_index;
      logic [15:0] job_id_out;
      logic [15:0] wait_time;
      logic [4:0]  queue_length;
      logic [15:0] served_count;
      logic [31:0] wait_sum;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  remaining;
      logic [31:0] arrival;
      logic        started;
   } job_entry_type;

endpackage

### rtl/sqd_if.sv
// Valid/ready channel interfaces for tick requests and event responses.
interface sqd_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] job_id;
   logic [3:0]  work_units;

   modport source (output valid, action, job_id, work_units, input ready);
   modport sink   (input valid, action, job_id, work_units, output ready);
endinterface

interface sqd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [1:0]  queue_index;
   logic [15:0] job_id_out;
   logic [15:0] wait_time;
   logic [4:0]  queue_length;
   logic [15:0] served_count;
   logic [31:0] wait_sum;
   logic        last;

   modport source (output valid, event_kind, queue_index, job_id_out, wait_time,
                   queue_length, served_count, wait_sum, last, input ready);
   modport sink   (input valid, event_kind, queue_index, job_id_out, wait_time,
                   queue_length, served_count, wait_sum, last, output ready);
endinterface

### rtl/sqd_job_store.sv
// Job slot memory: one write port, one registered read port.
module sqd_job_store #(
   parameter int QUEUE_DEPTH = 16,
   parameter int AW          = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic                   rd_en,
   input  logic [AW-1:0]          addr,
   input  sqd_pkg::job_entry_type wr_data,
   output sqd_pkg::job_entry_type rd_data
);
   import sqd_pkg::*;

   localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;

   job_entry_type mem [ENTRIES];
   job_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sqd_rsp_stage.sv
// Output register holding one event transaction until the sink takes it.
module sqd_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sqd_pkg::rsp_item_type item,
   output logic                  slot_free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sqd_pkg::rsp_item_type out_item
);
   import sqd_pkg::*;

   logic         valid_ff;
   rsp_item_type item_ff;

   assign slot_free = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/sqd_ctrl.sv
// Tick sequencer: queue bookkeeping and read-modify-write of the job store.
module sqd_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int AW          = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sqd_pkg::req_item_type  in_item,
   input  logic                   slot_free,
   output logic                   emit,
   output sqd_pkg::rsp_item_type  emit_item,
   output logic                   mem_wr_en,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_addr,
   output sqd_pkg::job_entry_type mem_wr_data,
   input  sqd_pkg::job_entry_type mem_rd_data
);
   import sqd_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [LW-1:0] LEN_FULL = LW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] BASE_1   = AW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] BASE_2   = AW'(2 * QUEUE_DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ARRIVE = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_START  = 3'd3;
   localparam logic [2:0] S_SERVE  = 3'd4;
   localparam logic [2:0] S_TICK   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    q_ff, q_in;
   logic [31:0]   tick_ff, tick_in;
   logic [15:0]   arr_id_ff, arr_id_in;
   logic [3:0]    arr_units_ff, arr_units_in;
   logic [PW-1:0] head_ff [NUM_QUEUES];
   logic [PW-1:0] head_in [NUM_QUEUES];
   logic [PW-1:0] tail_ff [NUM_QUEUES];
   logic [PW-1:0] tail_in [NUM_QUEUES];
   logic [LW-1:0] len_ff [NUM_QUEUES];
   logic [LW-1:0] len_in [NUM_QUEUES];
   logic [15:0]   served_ff [NUM_QUEUES];
   logic [15:0]   served_in [NUM_QUEUES];
   logic [31:0]   wsum_ff [NUM_QUEUES];
   logic [31:0]   wsum_in [NUM_QUEUES];

   logic [1:0]    pick;
   logic [AW-1:0] base;
   logic [PW-1:0] head_cur, tail_cur;
   logic [LW-1:0] len_cur, len_dec, len_inc;
   logic [31:0]   wait32;
   logic [32:0]   sum33;
   logic [31:0]   wsum_new;
   logic [15:0]   served_new;
   logic [15:0]   wait16;

   // Shortest queue, ties to the lowest index.
   always_comb begin
      if (len_ff[0] <= len_ff[1] && len_ff[0] <= len_ff[2]) begin
         pick = 2'd0;
      end else if (len_ff[1] <= len_ff[2]) begin
         pick = 2'd1;
      end else begin
         pick = 2'd2;
      end
   end

   always_comb begin
      case (q_ff)
         2'd1:    base = BASE_1;
         2'd2:    base = BASE_2;
         default: base = '0;
      endcase
   end

   assign head_cur   = head_ff[q_ff];
   assign tail_cur   = tail_ff[q_ff];
   assign len_cur    = len_ff[q_ff];
   assign len_dec    = len_cur - 1'b1;
   assign len_inc    = len_cur + 1'b1;
   assign wait32     = tick_ff - mem_rd_data.arrival;
   assign sum33      = {1'b0, wsum_ff[q_ff]} + {1'b0, wait32};
   assign wsum_new   = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
   assign served_new = (served_ff[q_ff] == 16'hFFFF) ? served_ff[q_ff]
                                                      : served_ff[q_ff] + 16'd1;
   assign wait16     = (|wait32[31:16]) ? 16'hFFFF : wait32[15:0];

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      tick_in      = tick_ff;
      arr_id_in    = arr_id_ff;
      arr_units_in = arr_units_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      len_in       = len_ff;
      served_in    = served_ff;
      wsum_in      = wsum_ff;
      in_ready     = 1'b0;
      emit         = 1'b0;
      emit_item    = '0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_addr     = base + AW'(head_cur);
      mem_wr_data  = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               arr_id_in    = in_item.job_id;
               arr_units_in = in_item.work_units;
               if (in_item.action) begin
                  q_in     = pick;
                  state_in = S_ARRIVE;
               end else begin
                  q_in     = 2'd0;
                  state_in = S_READ;
               end
            end
         end

         S_ARRIVE: begin
            if (slot_free) begin
               emit                  = 1'b1;
               emit_item.queue_index = q_ff;
               emit_item.job_id_out  = arr_id_ff;
               emit_item.served_count = served_ff[q_ff];
               emit_item.wait_sum    = wsum_ff[q_ff];
               if (len_cur == LEN_FULL) begin
                  emit_item.event_kind   = EV_REJECT;
                  emit_item.queue_length = 5'(len_cur);
               end else begin
                  emit_item.event_kind   = EV_QUEUED;
                  emit_item.queue_length = 5'(len_inc);
                  mem_wr_en              = 1'b1;
                  mem_addr               = base + AW'(tail_cur);
                  mem_wr_data.id         = arr_id_ff;
                  mem_wr_data.remaining  = (arr_units_ff == 4'd0) ? 4'd1 : arr_units_ff;
                  mem_wr_data.arrival    = tick_ff;
                  mem_wr_data.started    = 1'b0;
                  tail_in[q_ff]          = (tail_cur == PTR_LAST) ? '0 : tail_cur + 1'b1;
                  len_in[q_ff]           = len_inc;
               end
               q_in     = 2'd0;
               state_in = S_READ;
            end
         end

         S_READ: begin
            if (len_cur == '0) begin
               if (q_ff == 2'd2) begin
                  state_in = S_TICK;
               end else begin
                  q_in = q_ff + 2'd1;
               end
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_START;
            end
         end

         S_START: begin
            if (mem_rd_data.started) begin
               state_in = S_SERVE;
            end else if (slot_free) begin
               emit                   = 1'b1;
               emit_item.event_kind   = EV_START;
               emit_item.queue_index  = q_ff;
               emit_item.job_id_out   = mem_rd_data.id;
               emit_item.queue_length = 5'(len_cur);
               emit_item.served_count = served_ff[q_ff];
               emit_item.wait_sum     = wsum_ff[q_ff];
               state_in               = S_SERVE;
            end
         end

         S_SERVE: begin
            if (mem_rd_data.remaining <= 4'd1) begin
               if (slot_free) begin
                  emit                   = 1'b1;
                  emit_item.event_kind   = EV_DEPART;
                  emit_item.queue_index  = q_ff;
                  emit_item.job_id_out   = mem_rd_data.id;
                  emit_item.wait_time    = wait16;
                  emit_item.queue_length = 5'(len_dec);
                  emit_item.served_count = served_new;
                  emit_item.wait_sum     = wsum_new;
                  head_in[q_ff]          = (head_cur == PTR_LAST) ? '0 : head_cur + 1'b1;
                  len_in[q_ff]           = len_dec;
                  served_in[q_ff]        = served_new;
                  wsum_in[q_ff]          = wsum_new;
                  if (q_ff == 2'd2) begin
                     state_in = S_TICK;
                  end else begin
                     q_in     = q_ff + 2'd1;
                     state_in = S_READ;
                  end
               end
            end else begin
               // Write back the head job with one unit spent.
               mem_wr_en             = 1'b1;
               mem_wr_data.remaining = mem_rd_data.remaining - 4'd1;
               mem_wr_data.started   = 1'b1;
               if (q_ff == 2'd2) begin
                  state_in = S_TICK;
               end else begin
                  q_in     = q_ff + 2'd1;
                  state_in = S_READ;
               end
            end
         end

         S_TICK: begin
            if (slot_free) begin
               emit                 = 1'b1;
               emit_item.event_kind = EV_TICK;
               emit_item.last       = 1'b1;
               tick_in              = tick_ff + 32'd1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         q_ff      <= 2'd0;
         tick_ff   <= '0;
         head_ff   <= '{default: '0};
         tail_ff   <= '{default: '0};
         len_ff    <= '{default: '0};
         served_ff <= '{default: '0};
         wsum_ff   <= '{default: '0};
      end else begin
         state_ff  <= state_in;
         q_ff      <= q_in;
         tick_ff   <= tick_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         len_ff    <= len_in;
         served_ff <= served_in;
         wsum_ff   <= wsum_in;
      end
   end

   always_ff @(posedge clock) begin
      arr_id_ff    <= arr_id_in;
      arr_units_ff <= arr_units_in;
   end

endmodule

### rtl/shortest_queue_dispatch_service.sv
// One tick at a time: a new tick transaction is accepted only once the previous one has
// closed with its tick event; each non-empty queue adds steps, an arrival adds its own step,
// and a stalling sink holds the sequence.
// Each non-empty queue costs a read, a start step and a serve step on the job store port.
// Reset (synchronous, active high) empties all queues and clears counters and tick count;
// the job store itself is not cleared, slots are only read once written.
module shortest_queue_dispatch_service #(
   parameter int QUEUE_DEPTH = sqd_pkg::SQD_QUEUE_DEPTH
) (
   input logic      clock,
   input logic      reset,
   sqd_req_if.sink  req,
   sqd_rsp_if.source rsp
);
   import sqd_pkg::*;

   // Three queues of QUEUE_DEPTH slots share one store, queue q at q*QUEUE_DEPTH.
   localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

   req_item_type  req_item;
   rsp_item_type  emit_item;
   rsp_item_type  out_item;
   logic          emit;
   logic          slot_free;
   logic          mem_wr_en;
   logic          mem_rd_en;
   logic [AW-1:0] mem_addr;
   job_entry_type mem_wr_data;
   job_entry_type mem_rd_data;

   // Gather the request payload into one bundle for the sequencer.
   assign req_item.action     = req.action;
   assign req_item.job_id     = req.job_id;
   assign req_item.work_units = req.work_units;

   // Sequencer: takes a tick transaction, places or rejects any arrival, then walks the
   // queues in order 0, 1, 2 reading each head job, and closes with tick done.
   sqd_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .AW          (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .in_item     (req_item),
      .slot_free   (slot_free),
      .emit        (emit),
      .emit_item   (emit_item),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   // Job slots: id, remaining units, arrival tick and started flag.
   sqd_job_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // Output register: the sequencer stalls on an emit only while it is full
   // and the sink holds ready low.
   sqd_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .item      (emit_item),
      .slot_free (slot_free),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_item  (out_item)
   );

   // Drive the response payload from the held event.
   assign rsp.event_kind   = out_item.event_kind;
   assign rsp.queue_index  = out_item.queue_index;
   assign rsp.job_id_out   = out_item.job_id_out;
   assign rsp.wait_time    = out_item.wait_time;
   assign rsp.queue_length = out_item.queue_length;
   assign rsp.served_count = out_item.served_count;
   assign rsp.wait_sum     = out_item.wait_sum;
   assign rsp.last         = out_item.last;

endmodule
